@@ design/ted_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ted_pkg
// Types and constants shared by the text encoding detector modules.
// ----------------------------------------------------------------------------
package ted_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CLASS_W = 3;
    localparam int unsigned TDATA_W = 8;
    localparam int unsigned COUNT_W = 2;
    localparam int unsigned PEND_W  = 2;

    typedef logic [BYTE_W-1:0]  byte_t;
    typedef logic [CLASS_W-1:0] class_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [PEND_W-1:0]  pend_t;

    localparam class_t CLASS_ANSI      = 3'd0;
    localparam class_t CLASS_UTF16LE   = 3'd1;
    localparam class_t CLASS_UTF16BE   = 3'd2;
    localparam class_t CLASS_UTF8BOM   = 3'd3;
    localparam class_t CLASS_UTF8NOBOM = 3'd4;

    localparam byte_t BOM_FF = 8'hFF;
    localparam byte_t BOM_FE = 8'hFE;
    localparam byte_t BOM_EF = 8'hEF;
    localparam byte_t BOM_BB = 8'hBB;
    localparam byte_t BOM_BF = 8'hBF;

    localparam byte_t MASK_C0 = 8'hC0;
    localparam byte_t MASK_E0 = 8'hE0;
    localparam byte_t MASK_F0 = 8'hF0;
    localparam byte_t LEAD_80 = 8'h80;
    localparam byte_t LEAD_C0 = 8'hC0;
    localparam byte_t LEAD_E0 = 8'hE0;

    localparam count_t COUNT_MAX = 2'd3;

    // Accepted byte as seen by the tracker
    typedef struct packed {
        logic  load;
        logic  last;
        byte_t data;
    } byte_in_t;

    // Result handed to the output register
    typedef struct packed {
        logic   load;
        logic   last;
        class_t enc_class;
    } class_out_t;

endpackage

@@ design/text_encoding_detector_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_encoding_detector_core
// BOM sniffing and UTF-8 validation over a byte stream, one class per stream.
// ----------------------------------------------------------------------------
// Channel   Dir  tdata               tlast        tuser
// s_        in   [7:0] data_byte     final_byte   -
// m_        out  [2:0] encoding_class -           -
//
// One byte per cycle while s_tready is high; the result appears in the cycle after the final
// byte is accepted, from a register that refills in the cycle it is taken.
// Per-byte work is a short update of the byte count, captured BOM bytes and
// continuation counter. Synchronous active-low reset clears all stream state.
// s_tready drops only while a result is held and m_tready is low.
// ----------------------------------------------------------------------------
module text_encoding_detector_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ted_pkg::TDATA_W-1:0]   s_tdata,    // [7:0] data_byte
    input  logic                          s_tlast,    // final_byte
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ted_pkg::TDATA_W-1:0]   m_tdata     // [2:0] encoding_class
);
    import ted_pkg::*;

    byte_in_t   byte_in;
    class_out_t class_out;
    logic       in_ready;

    assign s_tready     = in_ready;
    assign byte_in.load = s_tvalid && in_ready;
    assign byte_in.last = s_tlast;
    assign byte_in.data = s_tdata[BYTE_W-1:0];

    ted_tracker u_tracker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_in   (byte_in),
        .class_out (class_out)
    );

    ted_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .class_in (class_out),
        .in_ready (in_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

@@ design/ted_tracker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ted_tracker
// Per-stream state: first three bytes, byte count, UTF-8 sequence check,
// and classification of the stream on its final byte.
// ----------------------------------------------------------------------------
module ted_tracker (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ted_pkg::byte_in_t     byte_in,
    output ted_pkg::class_out_t   class_out
);
    import ted_pkg::*;

    byte_t  first_reg,  first_next;
    byte_t  second_reg, second_next;
    byte_t  third_reg,  third_next;
    count_t count_reg,  count_next;
    pend_t  pend_reg,   pend_next;
    logic   broken_reg, broken_next;
    class_t enc_class;

    // Next state including the current byte
    always_comb begin
        first_next  = first_reg;
        second_next = second_reg;
        third_next  = third_reg;
        count_next  = count_reg;
        pend_next   = pend_reg;
        broken_next = broken_reg;

        case (count_reg)
            2'd0:    first_next  = byte_in.data;
            2'd1:    second_next = byte_in.data;
            2'd2:    third_next  = byte_in.data;
            default: ;
        endcase
        if (count_reg != COUNT_MAX) begin
            count_next = count_reg + 2'd1;
        end

        if (pend_reg != '0) begin
            if ((byte_in.data & MASK_C0) != LEAD_80) begin
                broken_next = 1'b1;
            end
            pend_next = pend_reg - 2'd1;
        end else if (byte_in.data[BYTE_W-1] == 1'b0) begin
            pend_next = pend_reg;
        end else if ((byte_in.data & MASK_E0) == LEAD_C0) begin
            pend_next = 2'd1;
        end else if ((byte_in.data & MASK_F0) == LEAD_E0) begin
            pend_next = 2'd2;
        end else begin
            broken_next = 1'b1;
        end
    end

    always_comb begin
        if (count_next < 2'd2) begin
            enc_class = CLASS_ANSI;
        end else if (first_next == BOM_FF && second_next == BOM_FE) begin
            enc_class = CLASS_UTF16LE;
        end else if (first_next == BOM_FE && second_next == BOM_FF) begin
            enc_class = CLASS_UTF16BE;
        end else if (first_next == BOM_EF && second_next == BOM_BB
                     && third_next == BOM_BF) begin
            enc_class = CLASS_UTF8BOM;
        end else if (!broken_next && pend_next == '0) begin
            enc_class = CLASS_UTF8NOBOM;
        end else begin
            enc_class = CLASS_ANSI;
        end
    end

    assign class_out.load      = byte_in.load;
    assign class_out.last      = byte_in.last;
    assign class_out.enc_class = enc_class;

    always_ff @(posedge aclk) begin
        if (!aresetn || (byte_in.load && byte_in.last)) begin
            first_reg  <= '0;
            second_reg <= '0;
            third_reg  <= '0;
            count_reg  <= '0;
            pend_reg   <= '0;
            broken_reg <= 1'b0;
        end else if (byte_in.load) begin
            first_reg  <= first_next;
            second_reg <= second_next;
            third_reg  <= third_next;
            count_reg  <= count_next;
            pend_reg   <= pend_next;
            broken_reg <= broken_next;
        end
    end

    a_clear_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_in.load && byte_in.last |=>
            count_reg == '0 && pend_reg == '0 && !broken_reg)
        else $error("stream state not cleared after final byte");

    a_pend_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg != 2'd3)
        else $error("continuation count out of range");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_in.load && !byte_in.last && count_reg != COUNT_MAX |=>
            count_reg == $past(count_reg) + 2'd1)
        else $error("byte count did not advance");

endmodule

@@ design/ted_out_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ted_out_reg
// Result register on the master side; refills in the cycle it drains.
// ----------------------------------------------------------------------------
module ted_out_reg (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ted_pkg::class_out_t   class_in,
    output logic                  in_ready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [ted_pkg::TDATA_W-1:0] m_tdata   // [2:0] encoding_class
);
    import ted_pkg::*;

    logic   valid_reg, valid_next;
    class_t class_reg;

    assign in_ready = !valid_reg || m_tready;

    always_comb begin
        if (class_in.load) begin
            valid_next = class_in.last;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (class_in.load && class_in.last) begin
            class_reg <= class_in.enc_class;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(TDATA_W-CLASS_W){1'b0}}, class_reg};

    a_result_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        class_in.load && class_in.last |=> valid_reg)
        else $error("no result after final byte");

    a_no_result_mid: assert property (@(posedge aclk) disable iff (!aresetn)
        class_in.load && !class_in.last |=> !valid_reg)
        else $error("result raised for non-final byte");

endmodule
